FILE: design/tss_pkg.sv
`timescale 1ns / 1ps
package tss_pkg;
	localparam int TASKS = 8;
	localparam int QUEUE_DEPTH = 8;
	localparam int SEMS = 4;

	localparam logic [2:0] OP_SCHED   = 3'd0;
	localparam logic [2:0] OP_SLEEP   = 3'd1;
	localparam logic [2:0] OP_P       = 3'd2;
	localparam logic [2:0] OP_V       = 3'd3;
	localparam logic [2:0] OP_CREATE  = 3'd4;
	localparam logic [2:0] OP_QUANTUM = 3'd5;
	localparam logic [2:0] OP_CONSUME = 3'd6;
	localparam logic [2:0] OP_UNUSED  = 3'd7;

	localparam logic [1:0] ST_OK         = 2'd0;
	localparam logic [1:0] ST_SEM_FULL   = 2'd1;
	localparam logic [1:0] ST_QUEUE_FULL = 2'd2;

	localparam logic signed [17:0] COUNT_MAX = 18'sd131071;

	typedef struct packed {
		logic [2:0]  op;
		logic [1:0]  sem_index;
		logic [2:0]  task_index;
		logic [15:0] value;
	} req_t;

	typedef struct packed {
		logic [2:0] running_task;
		logic       none_ready;
		logic [1:0] sem_handle;
		logic [1:0] status;
	} rsp_t;

	// control broadcast from the sequencer to every task cell
	typedef struct packed {
		logic        dec_sleep;
		logic        refill;
		logic        scan;
		logic        set_sleep;
		logic        set_wait;
		logic        clr_wait;
		logic        set_quantum;
		logic        consume;
		logic [15:0] value;
	} cell_ctl_t;
endpackage

FILE: design/tss_stream_if.sv
`timescale 1ns / 1ps
interface tss_stream_if #(parameter type T = logic) ();
	logic valid;
	logic ready;
	T     data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

FILE: design/tss_task_cell.sv
`timescale 1ns / 1ps
// One task slot. During a scan the running best (ticks, index, found) passes
// through the cell and moves to the next cell; the chain is registered cell by
// cell, one hop per cycle.
module tss_task_cell #(
	parameter int TW = 3,
	parameter int IDX = 0
) (
	input  logic                clk,
	input  logic                arst_n,
	input  tss_pkg::cell_ctl_t  ctl,
	input  logic                sel_cur,
	input  logic                sel_q,
	input  logic [15:0]         best_in,
	input  logic [TW-1:0]       bidx_in,
	input  logic                found_in,
	output logic [15:0]         best_out,
	output logic [TW-1:0]       bidx_out,
	output logic                found_out
);
	import tss_pkg::*;

	logic [15:0] ticks_q, sleep_q, quantum_q;
	logic        wait_q;
	logic        elig;
	logic        take;

	assign elig = !wait_q && sleep_q == 16'd0;
	assign take = elig && ticks_q > best_in;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ticks_q <= '0;
			sleep_q <= '0;
			quantum_q <= '0;
			wait_q <= 1'b0;
			best_out <= '0;
			bidx_out <= '0;
			found_out <= 1'b0;
		end else begin
			if (ctl.dec_sleep && sleep_q != 16'd0)
				sleep_q <= sleep_q - 16'd1;
			if (ctl.set_sleep && sel_cur)
				sleep_q <= ctl.value;
			if (ctl.set_wait && sel_cur)
				wait_q <= 1'b1;
			if (ctl.clr_wait && sel_q)
				wait_q <= 1'b0;
			if (ctl.set_quantum && sel_q)
				quantum_q <= ctl.value;
			if (ctl.refill && elig)
				ticks_q <= quantum_q;
			if (ctl.consume && sel_cur && ticks_q != 16'd0)
				ticks_q <= ticks_q - 16'd1;
			if (ctl.scan) begin
				if (take) begin
					best_out <= ticks_q;
					bidx_out <= TW'(IDX);
					found_out <= 1'b1;
				end else begin
					best_out <= best_in;
					bidx_out <= bidx_in;
					found_out <= found_in;
				end
			end
		end
	end
endmodule

FILE: design/task_scheduler_with_semaphores_unit.sv
`timescale 1ns / 1ps
// Time-slice scheduler with counting semaphores, one operation at a time.
// Tasks sit in a chain of cells; a schedule walks the chain once, one cell
// per cycle, and, when nothing has ticks, refills and walks it again. A
// schedule or sleep, and a P that blocks, go through the decrement, scan and
// pick states. P and V go through the queue-read state; a V that wakes a
// waiter then also goes through the wake state, which uses the registered
// wait-queue memory read. Create, quantum, consume and the unused op go
// straight to the output state. Each operation gives one result, held until
// it is taken; the next request is accepted only after that. TASKS,
// QUEUE_DEPTH and SEMS are fixed in tss_pkg.
module task_scheduler_with_semaphores_unit (
	input logic clk,
	input logic arst_n,
	tss_stream_if.sink   req,
	tss_stream_if.source rsp
);
	import tss_pkg::*;

	localparam int TW = 3;
	localparam int QW = $clog2(QUEUE_DEPTH);
	localparam int SW = (SEMS > 1) ? $clog2(SEMS) : 1;
	localparam int CW = $clog2(SEMS + 1);
	localparam int NW = $clog2(TASKS + 1);
	localparam int AW = $clog2(SEMS * QUEUE_DEPTH);

	localparam logic [2:0] S_IDLE = 3'd0, S_DEC = 3'd1, S_SCAN = 3'd2,
		S_PICK = 3'd3, S_REFILL = 3'd4, S_VREAD = 3'd5, S_VWAKE = 3'd6,
		S_OUT = 3'd7;

	logic [2:0]  state_q;
	req_t        req_q;
	logic        second_q;
	logic [NW-1:0] cnt_q;
	logic [TW-1:0] cur_q;
	logic [CW-1:0] created_q;
	logic signed [17:0] count_q [SEMS];
	logic [QW-1:0] head_q [SEMS];
	logic [QW-1:0] tail_q [SEMS];
	logic [TW-1:0] queue_mem [SEMS*QUEUE_DEPTH];
	logic [TW-1:0] qrd_q;
	rsp_t        out_q;
	logic        out_valid_q;
	cell_ctl_t   ctl;

	logic [15:0] best [TASKS+1];
	logic [TW-1:0] bidx [TASKS+1];
	logic        found [TASKS+1];

	logic [SW-1:0] s;
	logic          s_ok;
	logic signed [17:0] cnt_m1, cnt_p1;
	logic [QW-1:0] nxt;
	logic [AW-1:0] wr_addr, rd_addr;
	logic          create_ok;

	assign s = SW'(req_q.sem_index);
	assign s_ok = 32'(req_q.sem_index) < SEMS;
	assign cnt_m1 = count_q[s] - 18'sd1;
	assign cnt_p1 = (count_q[s] < COUNT_MAX) ? count_q[s] + 18'sd1 : count_q[s];
	assign nxt = (32'(tail_q[s]) == QUEUE_DEPTH - 1) ? '0 : tail_q[s] + QW'(1);
	assign wr_addr = AW'(32'(s) * QUEUE_DEPTH + 32'(tail_q[s]));
	assign rd_addr = AW'(32'(s) * QUEUE_DEPTH + 32'(head_q[s]));
	assign create_ok = 32'(created_q) < SEMS;

	assign req.ready = state_q == S_IDLE && !out_valid_q;
	assign rsp.valid = out_valid_q;
	assign rsp.data = out_q;

	// seed of the scan chain
	assign best[0] = '0;
	assign bidx[0] = '0;
	assign found[0] = 1'b0;

	always_comb begin
		ctl = '0;
		ctl.value = req_q.value;
		ctl.dec_sleep = state_q == S_DEC;
		ctl.scan = state_q == S_SCAN;
		ctl.refill = state_q == S_REFILL;
		ctl.clr_wait = state_q == S_VWAKE;
		if (state_q == S_IDLE && req.valid && req.ready) begin
			ctl.value = req.data.value;
			ctl.set_sleep = req.data.op == OP_SLEEP;
			ctl.set_quantum = req.data.op == OP_QUANTUM;
			ctl.consume = req.data.op == OP_CONSUME;
		end
		// only a P that actually enqueues blocks the caller
		if (state_q == S_VREAD && req_q.op == OP_P && s_ok && cnt_m1 < 0
				&& nxt != head_q[s])
			ctl.set_wait = 1'b1;
	end

	for (genvar i = 0; i < TASKS; i++) begin : g_cell
		logic selq;
		always_comb begin
			if (state_q == S_VWAKE)
				selq = qrd_q == TW'(i) && 32'(qrd_q) < TASKS;
			else
				selq = req.data.task_index == TW'(i);
		end
		tss_task_cell #(.TW(TW), .IDX(i)) u_cell (
			.clk(clk), .arst_n(arst_n), .ctl(ctl),
			.sel_cur(cur_q == TW'(i)), .sel_q(selq),
			.best_in(best[i]), .bidx_in(bidx[i]), .found_in(found[i]),
			.best_out(best[i+1]), .bidx_out(bidx[i+1]), .found_out(found[i+1])
		);
	end

	always_ff @(posedge clk) begin
		if (state_q == S_VREAD && req_q.op == OP_P)
			queue_mem[wr_addr] <= cur_q;
		qrd_q <= queue_mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			out_valid_q <= 1'b0;
			out_q <= '0;
			req_q <= '0;
			second_q <= 1'b0;
			cnt_q <= '0;
			cur_q <= '0;
			created_q <= '0;
			for (int k = 0; k < SEMS; k++) begin
				count_q[k] <= '0;
				head_q[k] <= '0;
				tail_q[k] <= '0;
			end
		end else begin
			if (rsp.valid && rsp.ready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_IDLE: if (req.valid && req.ready) begin
					req_q <= req.data;
					out_q <= '{running_task: cur_q, none_ready: 1'b0,
						sem_handle: (req.data.op == OP_CREATE && create_ok)
							? 2'(created_q) : 2'd0,
						status: (req.data.op == OP_CREATE && !create_ok)
							? ST_SEM_FULL : ST_OK};
					second_q <= 1'b0;
					unique case (req.data.op)
						OP_SCHED, OP_SLEEP: state_q <= S_DEC;
						OP_P, OP_V: state_q <= S_VREAD;
						OP_CREATE: begin
							if (create_ok) begin
								count_q[SW'(created_q)] <= 18'(req.data.value);
								created_q <= created_q + CW'(1);
							end
							state_q <= S_OUT;
						end
						default: state_q <= S_OUT;
					endcase
				end
				S_VREAD: begin
					state_q <= S_OUT;
					if (s_ok) begin
						if (req_q.op == OP_P) begin
							if (cnt_m1 >= 0)
								count_q[s] <= cnt_m1;
							else if (nxt == head_q[s])
								out_q.status <= ST_QUEUE_FULL;
							else begin
								count_q[s] <= cnt_m1;
								tail_q[s] <= nxt;
								state_q <= S_DEC;
							end
						end else begin
							count_q[s] <= cnt_p1;
							if (cnt_p1 <= 0 && head_q[s] != tail_q[s]) begin
								head_q[s] <= (32'(head_q[s]) == QUEUE_DEPTH - 1)
									? '0 : head_q[s] + QW'(1);
								state_q <= S_VWAKE;
							end
						end
					end
				end
				S_VWAKE: state_q <= S_OUT;
				S_DEC: begin
					cnt_q <= '0;
					state_q <= S_SCAN;
				end
				S_SCAN: begin
					cnt_q <= cnt_q + NW'(1);
					if (32'(cnt_q) == TASKS - 1)
						state_q <= S_PICK;
				end
				S_PICK: begin
					if (found[TASKS]) begin
						cur_q <= bidx[TASKS];
						out_q.running_task <= bidx[TASKS];
						state_q <= S_OUT;
					end else if (!second_q) begin
						second_q <= 1'b1;
						state_q <= S_REFILL;
					end else begin
						out_q.none_ready <= 1'b1;
						out_q.running_task <= cur_q;
						state_q <= S_OUT;
					end
				end
				S_REFILL: begin
					cnt_q <= '0;
					state_q <= S_SCAN;
				end
				S_OUT: begin
					out_q.running_task <= out_q.none_ready || req_q.op > OP_SLEEP
						&& !(req_q.op == OP_P && out_q.status == ST_OK) ?
						cur_q : out_q.running_task;
					out_valid_q <= 1'b1;
					state_q <= S_IDLE;
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end
endmodule
